// ===== hw/rtl/i2d_pkg.sv =====
// Package for the integer to decimal text core: widths, ASCII codes, handoff type.
// No dependencies; imported by every other file of the core.
package i2d_pkg;

  localparam int WORD_W  = 32;                 // input integer width
  localparam int DIGITS  = 10;                 // decimal digits of 2^32-1
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CHAR_W  = 8;
  localparam int CNT_W   = $clog2(WORD_W);
  localparam int DIG_W   = $clog2(DIGITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // Converted number handed from the converter to the character emitter.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } i2d_num_t;

endpackage

// ===== hw/rtl/i2d_if.sv =====
// Valid/ready channel interfaces for the integer word in and the character word out.
// Depends on i2d_pkg.
interface i2d_num_if
  import i2d_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2d_text_if
  import i2d_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hw/rtl/int_to_decimal_ascii_core.sv =====
// Signed 32-bit integer to decimal ASCII text, one character word per output handshake.
// An accepted number passes the 32-step shift-and-add-3 loop, the handoff and the emitter
// load before its first character reaches the output register. Converting the next number
// overlaps emitting the previous one; a receiver that is not ready stalls the emission.
// Reset (rst, synchronous, active high) empties both stages; no state survives a number.
// Depends on i2d_pkg, i2d_if, i2d_dabble and i2d_emit.
module int_to_decimal_ascii_core
  import i2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  i2d_num_if.sink    num,   // integer words in
  i2d_text_if.source text   // character words out, last marks end of a number
);

  // handoff between converter and emitter: the converter holds a finished
  // number until the emitter has registered every character of the previous one
  logic     conv_valid;
  logic     conv_ready;
  i2d_num_t conv;

  // stage 1: sign split and binary to BCD, one input bit per cycle
  i2d_dabble u_dabble (
    .clk       (clk),
    .rst       (rst),
    .num       (num),
    .res_valid (conv_valid),
    .res_ready (conv_ready),
    .res       (conv)
  );

  // stage 2: leading zero skip, optional '-', then one digit per cycle unless stalled
  i2d_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (conv_valid),
    .load_ready (conv_ready),
    .load       (conv),
    .text       (text)
  );

endmodule

// ===== hw/rtl/i2d_dabble.sv =====
// Binary to BCD converter: sign/magnitude split, then shift-and-add-3, one bit a cycle.
// Depends on i2d_pkg and i2d_num_if.
module i2d_dabble
  import i2d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  i2d_num_if.sink   num,
  output logic      res_valid,
  input  logic      res_ready,
  output i2d_num_t  res
);

  typedef enum logic [2:0] {
    DB_IDLE = 3'b001,
    DB_RUN  = 3'b010,
    DB_HOLD = 3'b100
  } db_state_t;

  db_state_t         state;
  logic [WORD_W-1:0] mag;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [CNT_W-1:0]  cnt;
  logic              neg;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd[4*k +: 4];
      end
    end
  end

  assign num.ready = (state == DB_IDLE);
  assign res_valid = (state == DB_HOLD);
  assign res.neg   = neg;
  assign res.bcd   = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DB_IDLE;
    end else begin
      unique case (state)
        DB_IDLE: begin
          if (num.valid) begin
            neg   <= num.value[WORD_W-1];
            mag   <= num.value[WORD_W-1] ? (~num.value + 1'b1) : num.value;
            bcd   <= '0;
            cnt   <= '0;
            state <= DB_RUN;
          end
        end
        DB_RUN: begin
          bcd <= {bcd_adj[BCD_W-2:0], mag[WORD_W-1]};
          mag <= {mag[WORD_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(WORD_W - 1)) begin
            state <= DB_HOLD;
          end
        end
        DB_HOLD: begin
          if (res_ready) begin
            state <= DB_IDLE;
          end
        end
        default: begin
          state <= DB_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/i2d_emit.sv =====
// Emitter: drops leading zeros, sends '-', digits one a cycle if not stalled; output is registered.
// Depends on i2d_pkg and i2d_text_if.
module i2d_emit
  import i2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  output logic       load_ready,
  input  i2d_num_t   load,
  i2d_text_if.source text
);

  typedef enum logic [1:0] {
    EM_IDLE = 2'b01,
    EM_SEND = 2'b10
  } em_state_t;

  em_state_t         state;
  logic [BCD_W-1:0]  digits;
  logic [DIG_W-1:0]  rem;
  logic              minus;
  logic [DIG_W-1:0]  lead;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_free;

  // position of the highest nonzero digit; zero gives position 0
  always_comb begin
    lead = '0;
    for (int k = 0; k < DIGITS; k++) begin
      if (load.bcd[4*k +: 4] != 4'd0) begin
        lead = DIG_W'(k);
      end
    end
  end

  assign load_ready     = (state == EM_IDLE);
  assign out_free       = !out_valid || text.ready;
  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        EM_IDLE: begin
          // last word of the previous number drains here
          if (out_valid && text.ready) begin
            out_valid <= 1'b0;
          end
          if (load_valid) begin
            digits <= load.bcd << {(DIG_W'(DIGITS - 1) - lead), 2'b00};
            rem    <= lead;
            minus  <= load.neg;
            state  <= EM_SEND;
          end
        end
        EM_SEND: begin
          // a held word that is not taken keeps out_valid high
          if (out_free) begin
            out_valid <= 1'b1;
            if (minus) begin
              out_char <= ASCII_MINUS;
              out_last <= 1'b0;
              minus    <= 1'b0;
            end else begin
              out_char <= ASCII_ZERO + {4'd0, digits[BCD_W-1 -: 4]};
              out_last <= (rem == '0);
              digits   <= {digits[BCD_W-5:0], 4'd0};
              rem      <= rem - 1'b1;
              if (rem == '0) begin
                state <= EM_IDLE;
              end
            end
          end
        end
        default: begin
          state <= EM_IDLE;
        end
      endcase
    end
  end

endmodule
